FILE: hw/rtl/mbe_pkg.sv
package mbe_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned MaxIterDefault = 1000;
  localparam int unsigned MaxDimDefault  = 4096;

  // Field widths.
  localparam int PixW     = 12;
  localparam int DimW     = 13;
  localparam int CountW   = 10;
  localparam int QW       = 32;
  localparam int FracBits = 28;
  localparam int ProdW    = 2 * QW;

  // The mapping dividend is 4 * pixel * 2^28, which has PixW + 30 bits.
  localparam int NumW = PixW + 2 + FracBits;

  // Depth of the queue between the mapping front and the iteration engine.
  localparam int FifoDepth = 2;

  // Reset values of the configuration registers.
  localparam logic [DimW-1:0] WidthReset  = 13'd800;
  localparam logic [DimW-1:0] HeightReset = 13'd600;

  // Signed Q4.28 value.
  typedef logic signed [QW-1:0] q_t;

  localparam q_t QMax = 32'sh7FFF_FFFF;
  localparam q_t QMin = 32'sh8000_0000;

  // Escape bound: 4 in Q8.56.
  localparam logic [ProdW-1:0] MagLimit = 64'h0400_0000_0000_0000;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // One mapped pixel, handed from the front to the engine.
  typedef struct packed {
    logic [PixW-1:0] px;
    logic [PixW-1:0] py;
    q_t              cre;
    q_t              cim;
  } point_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV_X,
    F_DIV_Y,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_MUL_RR,
    C_MUL_II,
    C_MUL_RI,
    C_CHECK,
    C_DONE
  } core_state_e;

endpackage

FILE: hw/rtl/mandelbrot_escape_time.sv
// Escape-time evaluator for one pixel of a Mandelbrot image.
// Input queue: drive pixel_x_i/pixel_y_i and raise push; a beat is taken
// at a clock edge where push is high and full is low.
// Result queue: while empty is low, the oldest result is on out_x_o,
// out_y_o, escape_count_o and escaped_o; raise pop to take the beat.
// The cfg_* port sets image width (index 0) and height (index 1); write it
// only while no pixel is in flight.
// The front maps a pixel to c with a one-bit-per-cycle divider, one division
// per axis, and takes no new pixel until its mapped point is queued. The
// engine shares one 32x32 multiplier among the three products (re*re, im*im,
// re*im) of each check index and runs up to MAX_ITER - 1 check indexes per
// pixel. The slower of front and engine sets the throughput; a two-entry
// queue lets mapping overlap iteration.
// Reset restores width 800 and height 600 and empties both queues.
// full is high until the front is idle again. If the receiver stalls, the
// result waits in the output register, the engine holds its next finished
// pixel, and the front holds a mapped pixel once the queue is full.
module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int unsigned MAX_ITER = MaxIterDefault,
  parameter int unsigned MAX_DIM  = MaxDimDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [DimW-1:0]   cfg_data_i,
  input  logic              push,
  output logic              full,
  input  logic [PixW-1:0]   pixel_x_i,
  input  logic [PixW-1:0]   pixel_y_i,
  output logic              empty,
  input  logic              pop,
  output logic [PixW-1:0]   out_x_o,
  output logic [PixW-1:0]   out_y_o,
  output logic [CountW-1:0] escape_count_o,
  output logic              escaped_o
);

  logic [DimW-1:0] width_q;
  logic [DimW-1:0] height_q;

  logic   fifo_push;
  logic   fifo_full;
  logic   fifo_pop;
  logic   fifo_empty;
  point_t front_point;
  point_t core_point;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  // Coordinate mapping.
  mbe_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .width_i    (width_q),
    .height_i   (height_q),
    .fifo_push_o(fifo_push),
    .fifo_full_i(fifo_full),
    .point_o    (front_point)
  );

  // Queue of mapped points.
  mbe_fifo #(
    .DEPTH(FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (fifo_push),
    .full_o   (fifo_full),
    .wr_data_i(front_point),
    .rd_i     (fifo_pop),
    .empty_o  (fifo_empty),
    .rd_data_o(core_point)
  );

  // Orbit iteration and result register.
  mbe_core #(
    .MAX_ITER(MAX_ITER)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (!fifo_empty),
    .in_pop_o      (fifo_pop),
    .point_i       (core_point),
    .pop           (pop),
    .empty         (empty),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .escape_count_o(escape_count_o),
    .escaped_o     (escaped_o)
  );

endmodule

FILE: hw/rtl/mbe_front.sv
module mbe_front import mbe_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [PixW-1:0] pixel_x_i,
  input  logic [PixW-1:0] pixel_y_i,
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  output logic            fifo_push_o,
  input  logic            fifo_full_i,
  output point_t          point_o
);

  localparam int StepW = $clog2(NumW);
  localparam logic signed [NumW+1:0] ReOffset = (NumW+2)'(3) <<< FracBits;
  localparam logic signed [NumW+1:0] ImOffset = (NumW+2)'(1) <<< FracBits;

  // A zero dimension counts as one, an oversized one as the maximum.
  function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    r = d;
    if (d == '0) begin
      r = DimW'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = DimW'(MAX_DIM);
    end
    return r;
  endfunction

  // Subtract the axis offset from a quotient and saturate to Q4.28.
  function automatic q_t map_axis(logic [NumW-1:0] q, logic signed [NumW+1:0] offset);
    logic signed [NumW+1:0] v;
    q_t r;
    v = $signed({2'b00, q}) - offset;
    if (v > (NumW+2)'(QMax)) begin
      r = QMax;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  front_state_e    state_q, state_d;
  logic [PixW-1:0] px_q, px_d;
  logic [PixW-1:0] py_q, py_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DimW-1:0] rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;
  q_t              cre_q, cre_d;
  q_t              cim_q, cim_d;

  logic [DimW-1:0] divisor;
  logic [DimW:0]   trial;
  logic            ge;
  logic [DimW-1:0] rem_next;
  logic [NumW-1:0] quotient;
  logic            last_step;

  // One restoring division step: one quotient bit a cycle, MSB first.
  always_comb begin
    divisor   = (state_q == F_DIV_X) ? eff_dim(width_i) : eff_dim(height_i);
    trial     = {rem_q, num_q[NumW-1]};
    ge        = (trial >= {1'b0, divisor});
    rem_next  = ge ? DimW'(trial - {1'b0, divisor}) : trial[DimW-1:0];
    quotient  = {num_q[NumW-2:0], ge};
    last_step = (step_q == StepW'(NumW - 1));
  end

  // Sequencer: take a pixel, divide for each axis, then hand the point on.
  always_comb begin
    state_d     = state_q;
    px_d        = px_q;
    py_d        = py_q;
    num_d       = num_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cre_d       = cre_q;
    cim_d       = cim_q;
    full        = 1'b1;
    fifo_push_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        full = 1'b0;
        if (push) begin
          px_d    = pixel_x_i;
          py_d    = pixel_y_i;
          num_d   = {pixel_x_i, {(NumW - PixW){1'b0}}};
          rem_d   = '0;
          step_d  = '0;
          state_d = F_DIV_X;
        end
      end
      F_DIV_X: begin
        num_d  = quotient;
        rem_d  = rem_next;
        step_d = step_q + StepW'(1);
        if (last_step) begin
          cre_d   = map_axis(quotient, ReOffset);
          num_d   = {py_q, {(NumW - PixW){1'b0}}};
          rem_d   = '0;
          step_d  = '0;
          state_d = F_DIV_Y;
        end
      end
      F_DIV_Y: begin
        num_d  = quotient;
        rem_d  = rem_next;
        step_d = step_q + StepW'(1);
        if (last_step) begin
          cim_d   = map_axis(quotient, ImOffset);
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        fifo_push_o = !fifo_full_i;
        if (!fifo_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    cre_q  <= cre_d;
    cim_q  <= cim_d;
  end

  assign point_o = '{px: px_q, py: py_q, cre: cre_q, cim: cim_q};

endmodule

FILE: hw/rtl/mbe_fifo.sv
module mbe_fifo import mbe_pkg::*; #(
  parameter int DEPTH = FifoDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  output logic   full_o,
  input  point_t wr_data_i,
  input  logic   rd_i,
  output logic   empty_o,
  output point_t rd_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  point_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW:0]   cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o    = (cnt_q == (PtrW+1)'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (rd_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + (PtrW+1)'(1);
      end else if (!wr_i && rd_i) begin
        cnt_q <= cnt_q - (PtrW+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

FILE: hw/rtl/mbe_core.sv
module mbe_core import mbe_pkg::*; #(
  parameter int unsigned MAX_ITER = MaxIterDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_pop_o,
  input  point_t            point_i,
  input  logic              pop,
  output logic              empty,
  output logic [PixW-1:0]   out_x_o,
  output logic [PixW-1:0]   out_y_o,
  output logic [CountW-1:0] escape_count_o,
  output logic              escaped_o
);

  localparam int CntW = $clog2(MAX_ITER);
  localparam logic [CntW-1:0] LastIter = CntW'(MAX_ITER - 1);

  // Saturate a wide sum to Q4.28.
  function automatic q_t sat_q(logic signed [ProdW:0] v);
    q_t r;
    if (v > (ProdW+1)'(QMax)) begin
      r = QMax;
    end else if (v < (ProdW+1)'(QMin)) begin
      r = QMin;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  core_state_e             state_q, state_d;
  q_t                      zre_q, zre_d;
  q_t                      zim_q, zim_d;
  q_t                      cre_q, cre_d;
  q_t                      cim_q, cim_d;
  logic [PixW-1:0]         px_q, px_d;
  logic [PixW-1:0]         py_q, py_d;
  logic [CntW-1:0]         iter_q, iter_d;
  logic                    res_esc_q, res_esc_d;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] re2_q;
  logic [ProdW-1:0]        mag_q;
  logic signed [ProdW-1:0] sq_q;

  logic                    out_valid_q, out_valid_d;
  logic [PixW-1:0]         out_x_q;
  logic [PixW-1:0]         out_y_q;
  logic [CntW-1:0]         out_cnt_q;
  logic                    out_esc_q;
  logic                    out_load;
  logic                    out_free;

  q_t                      op_a;
  q_t                      op_b;
  logic signed [ProdW:0]   sum_re;
  logic signed [ProdW:0]   sum_im;
  logic                    over;

  // Operand select for the shared multiplier: re*re, im*im, then re*im.
  always_comb begin
    op_a = zre_q;
    op_b = zre_q;
    case (state_q)
      C_MUL_II: begin
        op_a = zim_q;
        op_b = zim_q;
      end
      C_MUL_RI: begin
        op_b = zim_q;
      end
      default: begin
        op_a = zre_q;
      end
    endcase
  end

  // Next orbit point from the registered products; 2*re*im is one shift less.
  always_comb begin
    sum_re = (ProdW+1)'(sq_q >>> FracBits) + (ProdW+1)'(cre_q);
    sum_im = (ProdW+1)'(prod_q >>> (FracBits - 1)) + (ProdW+1)'(cim_q);
    over   = (mag_q > MagLimit);
  end

  assign out_free = !out_valid_q || pop;

  // Iteration sequencer.
  always_comb begin
    state_d   = state_q;
    zre_d     = zre_q;
    zim_d     = zim_q;
    cre_d     = cre_q;
    cim_d     = cim_q;
    px_d      = px_q;
    py_d      = py_q;
    iter_d    = iter_q;
    res_esc_d = res_esc_q;
    in_pop_o  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (in_valid_i) begin
          in_pop_o  = 1'b1;
          cre_d     = point_i.cre;
          cim_d     = point_i.cim;
          px_d      = point_i.px;
          py_d      = point_i.py;
          zre_d     = '0;
          zim_d     = '0;
          iter_d    = CntW'(1);
          res_esc_d = 1'b0;
          state_d   = C_MUL_RR;
        end
      end
      C_MUL_RR: begin
        state_d = C_MUL_II;
      end
      C_MUL_II: begin
        state_d = C_MUL_RI;
      end
      C_MUL_RI: begin
        state_d = C_CHECK;
      end
      C_CHECK: begin
        if (over) begin
          res_esc_d = 1'b1;
          state_d   = C_DONE;
        end else begin
          zre_d = sat_q(sum_re);
          zim_d = sat_q(sum_im);
          if (iter_q == LastIter) begin
            state_d = C_DONE;
          end else begin
            iter_d  = iter_q + CntW'(1);
            state_d = C_MUL_RR;
          end
        end
      end
      C_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers; the product register follows the multiplier directly.
  always_ff @(posedge clk_i) begin
    zre_q     <= zre_d;
    zim_q     <= zim_d;
    cre_q     <= cre_d;
    cim_q     <= cim_d;
    px_q      <= px_d;
    py_q      <= py_d;
    iter_q    <= iter_d;
    res_esc_q <= res_esc_d;
    prod_q    <= op_a * op_b;
    if (state_q == C_MUL_II) begin
      re2_q <= prod_q;
    end
    if (state_q == C_MUL_RI) begin
      mag_q <= $unsigned(re2_q) + $unsigned(prod_q);
      sq_q  <= re2_q - prod_q;
    end
    if (out_load) begin
      out_x_q   <= px_q;
      out_y_q   <= py_q;
      out_cnt_q <= iter_q;
      out_esc_q <= res_esc_q;
    end
  end

  assign empty          = !out_valid_q;
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;
  assign escape_count_o = CountW'(out_cnt_q);
  assign escaped_o      = out_esc_q;

`ifndef ASSERT_OFF
  a_iter_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_CHECK) |-> (iter_q != '0))
    else $error("check index is zero");

  a_escape_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_CHECK) && over |=> (state_q == C_DONE) && res_esc_q)
    else $error("escape did not end the orbit");

  a_bounded_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_esc_q |-> (out_cnt_q == LastIter))
    else $error("bounded result with a short count");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_DONE) && out_free |=> out_valid_q)
    else $error("finished result not loaded");
`endif

endmodule

FILE: tb/mandelbrot_escape_time_checker.sv
`timescale 1ns / 100ps

// Watches both queue ports of the escape-time block, predicts the result of
// every accepted pixel and compares each result beat with the oldest
// prediction still waiting.
module mandelbrot_escape_time_checker import mbe_pkg::*; #(
  parameter int unsigned MaxIter = MaxIterDefault,
  parameter int unsigned MaxDim  = MaxDimDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [DimW-1:0]   cfg_data_i,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [PixW-1:0]   pixel_x_i,
  input  logic [PixW-1:0]   pixel_y_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  logic [PixW-1:0]   out_x_i,
  input  logic [PixW-1:0]   out_y_i,
  input  logic [CountW-1:0] escape_count_i,
  input  logic              escaped_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [PixW-1:0]   x;
    logic [PixW-1:0]   y;
    logic [CountW-1:0] count;
    logic              esc;
  } escape_result_t;

  localparam int MaxReports = 10;

  // Shadow copies of the two dimension registers.
  logic [DimW-1:0] width_q;
  logic [DimW-1:0] height_q;

  escape_result_t awaited_results[$];
  escape_result_t want;
  escape_result_t got;
  int             errors  = 0;
  int             reports = 0;

  // Saturate a wide value to the signed Q4.28 range.
  function automatic longint clamp_q(input longint v);
    if (v < longint'(QMin)) return longint'(QMin);
    if (v > longint'(QMax)) return longint'(QMax);
    return v;
  endfunction

  // Map a pixel index to one coordinate of c: floor(4 * p * 2^28 / dim) - offset.
  function automatic longint map_axis(input logic [PixW-1:0] p,
                                      input logic [DimW-1:0] dim,
                                      input longint offset);
    longint unsigned d;
    longint unsigned num;
    longint unsigned quo;
    d = dim;
    if (d == 0) d = 1;
    else if (d > MaxDim) d = MaxDim;
    num = longint'(p) << (FracBits + 2);
    quo = num / d;
    return clamp_q(longint'(quo) - offset);
  endfunction

  // Iterate z = z*z + c from zero and report the check index of escape.
  function automatic escape_result_t predict_escape(input logic [PixW-1:0] x,
                                                    input logic [PixW-1:0] y);
    longint          cre;
    longint          cim;
    longint          zre;
    longint          zim;
    longint          sq;
    longint          cr;
    longint unsigned mre;
    longint unsigned mim;
    longint unsigned mag;
    escape_result_t  r;
    cre     = map_axis(x, width_q, 64'sd3 << FracBits);
    cim     = map_axis(y, height_q, 64'sd1 << FracBits);
    zre     = 0;
    zim     = 0;
    r.x     = x;
    r.y     = y;
    r.count = CountW'(MaxIter - 1);
    r.esc   = 1'b0;
    for (int i = 1; i < MaxIter && !r.esc; i++) begin
      mre = (zre < 0) ? -zre : zre;
      mim = (zim < 0) ? -zim : zim;
      mag = mre * mre + mim * mim;
      if (mag > MagLimit) begin
        r.count = CountW'(i);
        r.esc   = 1'b1;
      end else begin
        // The magnitude bound keeps both products far from overflow.
        sq  = zre * zre - zim * zim;
        cr  = 2 * zre * zim;
        zre = clamp_q((sq >>> FracBits) + cre);
        zim = clamp_q((cr >>> FracBits) + cim);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      awaited_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Follow register writes.
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
          REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Every accepted pixel beat yields exactly one result.
      if (push_i && !full_i) begin
        awaited_results.insert(awaited_results.size(),
                               predict_escape(pixel_x_i, pixel_y_i));
      end

      // Compare a result beat against the oldest prediction.
      if (pop_i && !empty_i) begin
        got = '{x: out_x_i, y: out_y_i, count: escape_count_i, esc: escaped_i};
        if (awaited_results.size() == 0) begin
          errors++;
          if (reports < MaxReports) begin
            reports++;
            $display("unexpected result beat: x=%0d y=%0d count=%0d escaped=%0b",
                     got.x, got.y, got.count, got.esc);
          end
        end else begin
          want = awaited_results.pop_front();
          if (got.x !== want.x || got.y !== want.y ||
              got.count !== want.count || got.esc !== want.esc) begin
            errors++;
            if (reports < MaxReports) begin
              reports++;
              $display("result mismatch: expected x=%0d y=%0d count=%0d escaped=%0b",
                       want.x, want.y, want.count, want.esc);
              $display("                 actual   x=%0d y=%0d count=%0d escaped=%0b",
                       got.x, got.y, got.count, got.esc);
            end
          end
        end
      end

      fail_count_o <= errors;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

FILE: tb/mandelbrot_escape_time_tb.sv
`timescale 1ns / 100ps

// Drives pixels in bursts, pops results on a changing stall pattern and
// steps through several image sizes; the checker does all comparison.
module mandelbrot_escape_time_tb;
  import mbe_pkg::*;

  // Worst case per pixel is a full run of the engine plus mapping, gaps and
  // stalls; the limit takes that several times over.
  localparam int ItemsPerPhase = 75;
  localparam int RandomPhases  = 8;
  localparam int TailCycles    = 4 * MaxIterDefault + 200;
  localparam int LimitCycles   = 8_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [0:0]        cfg_idx_i;
  logic [DimW-1:0]   cfg_data_i;
  logic              push;
  logic              full;
  logic [PixW-1:0]   pixel_x_i;
  logic [PixW-1:0]   pixel_y_i;
  logic              empty;
  logic              pop;
  logic [PixW-1:0]   out_x_o;
  logic [PixW-1:0]   out_y_o;
  logic [CountW-1:0] escape_count_o;
  logic              escaped_o;

  int fail_count;
  int pending;
  int pixels_sent  = 0;
  int beats_popped = 0;
  int burst_left   = 0;
  bit quiet        = 1'b0;
  int pop_pct      = 100;
  int pop_hold     = 0;
  int cycles       = 0;

  mandelbrot_escape_time dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .push,
    .full,
    .pixel_x_i,
    .pixel_y_i,
    .empty,
    .pop,
    .out_x_o,
    .out_y_o,
    .escape_count_o,
    .escaped_o
  );

  mandelbrot_escape_time_checker checker_i (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .push_i         (push),
    .full_i         (full),
    .pixel_x_i,
    .pixel_y_i,
    .empty_i        (empty),
    .pop_i          (pop),
    .out_x_i        (out_x_o),
    .out_y_i        (out_y_o),
    .escape_count_i (escape_count_o),
    .escaped_i      (escaped_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Clock with a 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // The receiver picks a new pop rate whenever its hold counter runs out,
  // from never stalling down to popping rarely.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) beats_popped <= beats_popped + 1;
    if (pop_hold == 0) begin
      case ($urandom_range(0, 3))
        0:       pop_pct <= 100;
        1:       pop_pct <= 60;
        2:       pop_pct <= 25;
        default: pop_pct <= 4;
      endcase
      pop_hold <= 63;
    end else begin
      pop_hold <= pop_hold - 1;
    end
    pop <= ($urandom_range(0, 99) < pop_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LimitCycles) begin
      $display("mandelbrot_escape_time_tb: FAIL");
      $finish;
    end
  end

  // Offer one pixel beat and wait until it is taken; bursts end in a random gap, which quiet phases skip.
  task automatic issue_pixel(input logic [PixW-1:0] x, input logic [PixW-1:0] y);
    int gap;
    push      <= 1'b1;
    pixel_x_i <= x;
    pixel_y_i <= y;
    do @(posedge clk_i); while (full);
    pixels_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop sending and hold off until every pixel has come back.
  task automatic end_phase();
    push <= 1'b0;
    while (beats_popped < pixels_sent) @(posedge clk_i);
  endtask

  // Write both dimension registers on consecutive edges; only when idle.
  task automatic set_dims(input logic [DimW-1:0] w, input logic [DimW-1:0] h);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_IMAGE_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= REG_IMAGE_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    logic [PixW-1:0] x;
    logic [PixW-1:0] y;
    int              ew;
    int              eh;

    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_IMAGE_WIDTH;
    cfg_data_i <= '0;
    push       <= 1'b0;
    pixel_x_i  <= '0;
    pixel_y_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset dimensions 800 x 600: corners, the origin, the real axis down to
    // the tip at -2 where |z| stays exactly 2, and a point far outside.
    issue_pixel(12'd0, 12'd0);
    issue_pixel(12'd4095, 12'd4095);
    issue_pixel(12'd600, 12'd150);
    issue_pixel(12'd400, 12'd150);
    issue_pixel(12'd200, 12'd150);
    issue_pixel(12'd700, 12'd150);
    issue_pixel(12'd550, 12'd225);
    issue_pixel(12'd600, 12'd0);
    issue_pixel(12'd600, 12'd300);
    issue_pixel(12'd0, 12'd599);
    issue_pixel(12'd799, 12'd0);
    issue_pixel(12'd4095, 12'd0);
    end_phase();

    // A zero width counts as one, a height above the limit as the limit.
    set_dims(13'd0, 13'd8191);
    issue_pixel(12'd0, 12'd0);
    issue_pixel(12'd1, 12'd2048);
    issue_pixel(12'd4095, 12'd4095);
    end_phase();

    set_dims(13'd8191, 13'd0);
    issue_pixel(12'd0, 12'd0);
    issue_pixel(12'd3072, 12'd1);
    issue_pixel(12'd2048, 12'd2);
    end_phase();

    // Largest square image: c = 0 and c = -1 are both bounded.
    set_dims(13'd4096, 13'd4096);
    issue_pixel(12'd0, 12'd0);
    issue_pixel(12'd3072, 12'd1024);
    issue_pixel(12'd2048, 12'd1024);
    issue_pixel(12'd4095, 12'd4095);
    end_phase();

    // Random pixels under a series of image sizes; most fall inside the image.
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: begin
          w = WidthReset;
          h = HeightReset;
        end
        1: begin
          w = 13'd1;
          h = 13'd1;
        end
        2: begin
          w = 13'd4096;
          h = 13'd4096;
        end
        3: begin
          w = 13'd64;
          h = 13'd48;
        end
        4: begin
          w = DimW'($urandom_range(16, 4096));
          h = DimW'($urandom_range(16, 4096));
        end
        5: begin
          w = DimW'($urandom_range(4097, 8191));
          h = DimW'($urandom_range(0, 15));
        end
        6: begin
          w = DimW'($urandom_range(1, 300));
          h = DimW'($urandom_range(1, 300));
        end
        default: begin
          w = DimW'($urandom_range(0, 8191));
          h = DimW'($urandom_range(0, 8191));
        end
      endcase
      quiet = (p % 3 == 1);
      set_dims(w, h);
      ew = (w == 0) ? 1 : ((w > MaxDimDefault) ? MaxDimDefault : w);
      eh = (h == 0) ? 1 : ((h > MaxDimDefault) ? MaxDimDefault : h);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        x = PixW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(0, ew - 1));
        y = PixW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(0, eh - 1));
        issue_pixel(x, y);
      end
      end_phase();
    end

    // Leave room for any stray result beat before the verdict.
    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("mandelbrot_escape_time_tb: PASS");
    end else begin
      $display("mandelbrot_escape_time_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_front.sv
hw/rtl/mbe_fifo.sv
hw/rtl/mbe_core.sv
hw/rtl/mandelbrot_escape_time.sv
tb/mandelbrot_escape_time_checker.sv
tb/mandelbrot_escape_time_tb.sv
